// ===== design/sfc_pkg.sv =====
// Shared types and constants of the sorted frequency counter.
package sfc_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned OccW     = 7;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  // One result beat as it leaves the scan engine.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [OccW-1:0]          occ;
    logic                     last;
    logic                     ovf;
  } result_t;

endpackage

// ===== design/sfc_store.sv =====
// Value buffer: one write port, one read port with registered read data.
module sfc_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [AddrW-1:0]                  wr_addr_i,
  input  logic signed [sfc_pkg::ValueW-1:0] wr_data_i,
  input  logic                              rd_en_i,
  input  logic [AddrW-1:0]                  rd_addr_i,
  output logic signed [sfc_pkg::ValueW-1:0] rd_data_o
);
  import sfc_pkg::*;

  logic signed [ValueW-1:0] mem_q [Depth];
  logic signed [ValueW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/sfc_scan.sv =====
// Scan engine: one pass over the buffer per distinct value, smallest first.
module sfc_scan #(
  parameter int unsigned AddrW  = 6,
  parameter int unsigned CountW = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [CountW-1:0]                 count_i,
  input  logic                              ovf_i,
  output logic                              busy_o,
  output logic                              rd_en_o,
  output logic [AddrW-1:0]                  rd_addr_o,
  input  logic signed [sfc_pkg::ValueW-1:0] rd_data_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output sfc_pkg::result_t                  res_o
);
  import sfc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CountW-1:0] n_q, n_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              rv_q, rv_d;
  logic              rlast_q, rlast_d;
  logic signed [ValueW-1:0] prev_q, prev_d;
  logic              have_prev_q, have_prev_d;
  logic signed [ValueW-1:0] best_q, best_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              have_best_q, have_best_d;
  logic              greater_q, greater_d;
  logic              cand;

  // Only values above the one emitted last take part in this pass.
  assign cand = !have_prev_q || (rd_data_i > prev_q);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    rv_d        = 1'b0;
    rlast_d     = rlast_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    best_d      = best_q;
    cnt_d       = cnt_q;
    have_best_d = have_best_q;
    greater_d   = greater_q;
    rd_en_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_d         = count_i;
          ovf_d       = ovf_i;
          idx_d       = '0;
          have_prev_d = 1'b0;
          have_best_d = 1'b0;
          greater_d   = 1'b0;
          cnt_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q < n_q) begin
          rd_en_o = 1'b1;
          rv_d    = 1'b1;
          rlast_d = (idx_q == n_q - CountW'(1));
          idx_d   = idx_q + CountW'(1);
        end
        if (rv_q) begin
          if (cand) begin
            if (!have_best_q || (rd_data_i < best_q)) begin
              best_d      = rd_data_i;
              cnt_d       = CountW'(1);
              have_best_d = 1'b1;
              greater_d   = greater_q | have_best_q;
            end else if (rd_data_i == best_q) begin
              cnt_d = cnt_q + CountW'(1);
            end else begin
              greater_d = 1'b1;
            end
          end
          if (rlast_q) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          if (!greater_q) begin
            state_d = ST_IDLE;
          end else begin
            prev_d      = best_q;
            have_prev_d = 1'b1;
            have_best_d = 1'b0;
            greater_d   = 1'b0;
            cnt_d       = '0;
            idx_d       = '0;
            state_d     = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rv_q        <= 1'b0;
      idx_q       <= '0;
      have_prev_q <= 1'b0;
      have_best_q <= 1'b0;
      greater_q   <= 1'b0;
      cnt_q       <= '0;
      n_q         <= '0;
      rlast_q     <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      idx_q       <= idx_d;
      have_prev_q <= have_prev_d;
      have_best_q <= have_best_d;
      greater_q   <= greater_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      rlast_q     <= rlast_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    best_q <= best_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign rd_addr_o   = idx_q[AddrW-1:0];
  assign res_valid_o = (state_q == ST_EMIT);
  // value, occ, last, ovf from the top bit down
  assign res_o       = {best_q, OccW'(cnt_q), !greater_q, ovf_q};

  // Read data only comes back during a pass.
  a_rv_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == ST_SCAN))
    else $error("read data returned outside a scan pass");

  // An emitted result always counts at least one occurrence.
  a_occ_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (have_best_q && (cnt_q != '0)))
    else $error("result emitted without a counted value");

  // A pass never reads past the stored count.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= n_q))
    else $error("scan index ran past the item count");

  // A stalled result keeps its value and count.
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(best_q) && $stable(cnt_q)))
    else $error("stalled result changed");

endmodule

// ===== design/sorted_frequency_counter.sv =====
// Top level of the sorted frequency counter: load control, buffer and scan engine.
// Usage:
//   Input stream s_axis: one signed 32-bit value per beat in tdata, tlast marks
//   the last value of a set. Values are buffered, up to MAX_ITEMS of them;
//   further beats of the same set are dropped and flag overflow.
//   Loading takes one beat per cycle; no result appears until the tlast beat.
//   Output stream m_axis: one beat per distinct value, ascending, with its
//   occurrence count; tlast marks the largest value, tuser flags overflow.
//   Each result costs one read pass over the buffer (one read per cycle, read
//   data registered in the buffer, then compared), and tvalid rises once the
//   pass ends; a set with d distinct values drains in d passes plus the time
//   the receiver stalls.
//   s_axis_tready is low from the tlast beat until the final result is taken.
//   A stalled receiver simply holds the result beat; the next pass starts after
//   the beat is taken.
//   Reset empties the buffer count and clears the overflow flag; the buffer
//   contents themselves are not cleared (only written entries are read).
module sorted_frequency_counter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sfc_pkg::InDataW-1:0]    s_axis_tdata_i,  // [31:0] sample_value
  input  logic                           s_axis_tlast_i,  // final_item
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [sfc_pkg::OutDataW-1:0]   m_axis_tdata_o,  // [31:0] distinct_value,
                                                          // [38:32] occurrences, [39] zero
  output logic                           m_axis_tlast_o,  // final_result
  output logic                           m_axis_tuser_o   // [0] overflow
);
  import sfc_pkg::*;

  localparam int unsigned AddrW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CountW = $clog2(MAX_ITEMS + 1);

  logic [CountW-1:0] count_q, count_d;
  logic              dropped_q, dropped_d;
  logic              accept, full, wr_en, start;
  logic [CountW-1:0] start_count;
  logic              start_ovf;
  logic              busy;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic signed [ValueW-1:0] rd_data;
  result_t           res;

  // input beat taken only while no set is being reported
  assign s_axis_tready_o = !busy;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CountW'(MAX_ITEMS));
  assign wr_en           = accept && !full;
  assign start           = accept && s_axis_tlast_i;

  // count as seen after this beat is stored
  assign start_count = full ? count_q : count_q + CountW'(1);
  assign start_ovf   = dropped_q | full;

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (accept) begin
      if (s_axis_tlast_i) begin
        // scan engine latches the set; buffer is free for the next one
        count_d   = '0;
        dropped_d = 1'b0;
      end else begin
        count_d   = start_count;
        dropped_d = start_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  sfc_store #(
    .Depth (MAX_ITEMS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (s_axis_tdata_i[ValueW-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sfc_scan #(
    .AddrW  (AddrW),
    .CountW (CountW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .count_i     (start_count),
    .ovf_i       (start_ovf),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {1'b0, res.occ, res.value};
  assign m_axis_tlast_o = res.last;
  assign m_axis_tuser_o = res.ovf;

endmodule
